FILE: design/fgai_pkg.sv
// shared types and constants for the fuel gauge averaging and interpolation block
`default_nettype none
package fgai_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int AVG_W     = 16;
	localparam int CODE_W    = 15;
	localparam int TANK_W    = 11;
	localparam int FILL_W    = 14;
	localparam int FUEL_W    = 15;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_PTS   = 5;
	localparam int NUM_SEGS  = NUM_PTS - 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_EMPTY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_QUARTER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_HALF    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_3QUART  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_FULL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TANK         = 3'd5;

	// register values after reset
	localparam logic [CODE_W-1:0] RST_CODE_EMPTY   = 15'd20799;
	localparam logic [CODE_W-1:0] RST_CODE_QUARTER = 15'd19200;
	localparam logic [CODE_W-1:0] RST_CODE_HALF    = 15'd14400;
	localparam logic [CODE_W-1:0] RST_CODE_3QUART  = 15'd6720;
	localparam logic [CODE_W-1:0] RST_CODE_FULL    = 15'd1920;
	localparam logic [TANK_W-1:0] RST_TANK         = 11'd350;

	localparam logic [11:0]       SEG_CENTI  = 12'd2500;
	localparam logic [FILL_W-1:0] FILL_EMPTY = 14'd0;
	localparam logic [FILL_W-1:0] FILL_FULL  = 14'd10000;
	localparam logic [TANK_W-1:0] TANK_MAX   = 11'd2000;
	localparam logic [CODE_W-1:0] LITRE_DIV  = 15'd1000;

	// fill * tank stays below 2^25, so a rounded-up reciprocal of 1000 gives the exact quotient
	localparam int FUEL_SHIFT = 35;
	localparam int FUEL_RCP_W = 26;
	localparam logic [FUEL_RCP_W-1:0] FUEL_RECIP =
		FUEL_RCP_W'(((64'd1 << FUEL_SHIFT) + 64'(LITRE_DIV) - 64'd1) / 64'(LITRE_DIV));

	// interpolation divider: left-aligned dividend bits, remainder preloaded with the top bits
	localparam int DVD_W      = 27;
	localparam int REM_W      = 15;
	localparam int QUO_W      = 16;
	localparam int DIV_BPC    = 2;
	localparam int STEP_W     = 4;
	localparam int FILL_QBITS = 12;
	localparam logic [STEP_W-1:0] FILL_STEPS = STEP_W'(FILL_QBITS / DIV_BPC);

	typedef struct packed {
		logic [NUM_PTS-1:0][CODE_W-1:0] code;
		logic [TANK_W-1:0]              tank;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [REM_W-1:0]  rem_init;
		logic [DVD_W-1:0]  bits_init;
		logic [CODE_W-1:0] divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

FILE: design/fuel_gauge_average_interpolate.sv
// fuel gauge: window average of converter samples mapped to fill level and fuel amount
//
// samples arrive on in_valid / in_ready / adc_sample, one beat per sample. every WINDOW-th
// sample closes a window; its sum goes into a two-entry queue and the back end turns it into
// one result beat on out_valid / out_ready with average_code, fill_centi_percent and
// fuel_centi_liter. partial windows give no result.
// the front end takes one sample a cycle while in_ready is high, which drops only when the
// closing sample of a window finds the queue full. the back end takes one window sum at a
// time and skips the divider when the average misses the curve or lands on a zero-width
// segment. the average and the fuel amount come from reciprocal multiplies; only the
// interpolation divides, on a divider that retires two quotient bits a cycle. if the
// receiver stalls, the result waits in the output register, the back end holds its next
// result, the queue fills, and then the closing sample of a window is held off.
// configuration writes on cfg_valid / cfg_ready / cfg_index / cfg_data are taken every
// cycle; an index past the last register is ignored and data are cut to the register width.
// reset clears the window and the queue and loads the default calibration curve.
`default_nettype none
module fuel_gauge_average_interpolate import fgai_pkg::*; #(
	parameter int WINDOW = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] adc_sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [AVG_W-1:0]    average_code,
	output logic [FILL_W-1:0]          fill_centi_percent,
	output logic [FUEL_W-1:0]          fuel_centi_liter,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CODE_W-1:0]          cfg_data
);

	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW + 1);

	cfg_t                    cfg_q;
	q_stat_t                 q_stat;
	logic                    q_push;
	logic                    q_pop;
	logic signed [SUM_W-1:0] q_data;
	logic [SUM_W-1:0]        q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code[0] <= RST_CODE_EMPTY;
			cfg_q.code[1] <= RST_CODE_QUARTER;
			cfg_q.code[2] <= RST_CODE_HALF;
			cfg_q.code[3] <= RST_CODE_3QUART;
			cfg_q.code[4] <= RST_CODE_FULL;
			cfg_q.tank    <= RST_TANK;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CODE_EMPTY:   cfg_q.code[0] <= cfg_data;
				CFG_CODE_QUARTER: cfg_q.code[1] <= cfg_data;
				CFG_CODE_HALF:    cfg_q.code[2] <= cfg_data;
				CFG_CODE_3QUART:  cfg_q.code[3] <= cfg_data;
				CFG_CODE_FULL:    cfg_q.code[4] <= cfg_data;
				CFG_TANK:         cfg_q.tank    <= cfg_data[TANK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fgai_front #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.adc_sample (adc_sample),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_data     (q_data)
	);

	fgai_queue #(
		.DATA_W (SUM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	fgai_back #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.q_stat             (q_stat),
		.q_head             ($signed(q_head)),
		.q_pop              (q_pop),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.average_code       (average_code),
		.fill_centi_percent (fill_centi_percent),
		.fuel_centi_liter   (fuel_centi_liter)
	);

	// a closed window never meets a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_stat.full)
		else $error("window sum pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_stat.empty)
		else $error("back end popped an empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_centi_percent <= FILL_FULL)
		else $error("fill level beyond full");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fuel_centi_liter <= FUEL_W'(20000))
		else $error("fuel amount beyond largest tank");

endmodule
`default_nettype wire

FILE: design/fgai_front.sv
// front end: accepts samples, keeps the window sum and hands finished sums to the queue
`default_nettype none
module fgai_front import fgai_pkg::*; #(
	parameter int WINDOW = 10,
	parameter int SUM_W  = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] adc_sample,
	input  q_stat_t                    q_stat,
	output logic                       q_push,
	output logic signed [SUM_W-1:0]    q_data
);

	localparam int CNT_W = $clog2(WINDOW + 1);

	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_next;
	logic                    last;
	logic                    accept;

	assign last     = (count_q == CNT_W'(WINDOW - 1));
	assign sum_next = sum_q + SUM_W'(adc_sample);
	// only the closing beat of a window needs room in the queue
	assign in_ready = !last || !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && last;
	assign q_data   = sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			if (last) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_next;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/fgai_queue.sv
// two-entry queue of window sums between front and back end
`default_nettype none
module fgai_queue import fgai_pkg::*; #(
	parameter int DATA_W = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] head,
	output q_stat_t           stat
);

	localparam logic [1:0] DEPTH = 2'd2;

	logic [DATA_W-1:0] entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (cnt_q == DEPTH);
	assign stat.empty = (cnt_q == 2'd0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/fgai_div.sv
// restoring divider for the interpolation step, two quotient bits per cycle
`default_nettype none
module fgai_div import fgai_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [QUO_W-1:0] quot
);

	logic [REM_W-1:0]  rem_q;
	logic [DVD_W-1:0]  bits_q;
	logic [CODE_W-1:0] divisor_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_n;
	logic [DVD_W-1:0]  bits_n;

	always_comb begin
		logic [REM_W:0] t;
		rem_n  = rem_q;
		bits_n = bits_q;
		t      = '0;
		for (int i = 0; i < DIV_BPC; i++) begin
			t = {rem_n, bits_n[DVD_W-1]};
			if (t >= {1'b0, divisor_q}) begin
				rem_n  = REM_W'(t - {1'b0, divisor_q});
				bits_n = {bits_n[DVD_W-2:0], 1'b1};
			end else begin
				rem_n  = t[REM_W-1:0];
				bits_n = {bits_n[DVD_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= req.rem_init;
			bits_q    <= req.bits_init;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= rem_n;
			bits_q <= bits_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= req.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = bits_q[QUO_W-1:0];

endmodule
`default_nettype wire

FILE: design/fgai_back.sv
// back end: average, curve lookup, interpolation and fuel amount, one window sum at a time
`default_nettype none
module fgai_back import fgai_pkg::*; #(
	parameter int WINDOW = 10,
	parameter int SUM_W  = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  q_stat_t                  q_stat,
	input  logic signed [SUM_W-1:0]  q_head,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [AVG_W-1:0]  average_code,
	output logic [FILL_W-1:0]        fill_centi_percent,
	output logic [FUEL_W-1:0]        fuel_centi_liter
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_AVG_MUL   = 4'd1;
	localparam logic [3:0] S_AVG_SIGN  = 4'd2;
	localparam logic [3:0] S_SEG       = 4'd3;
	localparam logic [3:0] S_MUL1      = 4'd4;
	localparam logic [3:0] S_FILL_GO   = 4'd5;
	localparam logic [3:0] S_FILL_WAIT = 4'd6;
	localparam logic [3:0] S_MUL2      = 4'd7;
	localparam logic [3:0] S_FUEL_MUL  = 4'd8;
	localparam logic [3:0] S_EMIT      = 4'd9;

	// window magnitudes stay below 2^20, so a rounded-up reciprocal of WINDOW is exact
	localparam int AVG_SHIFT   = 24;
	localparam int AVG_RCP_W   = 25;
	localparam int AVG_PROD_W  = SUM_W + AVG_RCP_W;
	localparam int FUEL_PROD_W = 25 + FUEL_RCP_W;
	localparam logic [AVG_RCP_W-1:0] AVG_RECIP =
		AVG_RCP_W'(((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW);

	logic [3:0]              state_q;
	logic                    neg_q;
	logic [SUM_W-1:0]        mag_q;
	logic [AVG_PROD_W-1:0]   avg_prod_q;
	logic signed [AVG_W:0]   avg_q;
	logic [FILL_W-1:0]       base_q;
	logic [CODE_W-1:0]       span_q;
	logic [CODE_W-1:0]       dist_q;
	logic [DVD_W-1:0]        prod1_q;
	logic [24:0]             prod2_q;
	logic [FUEL_PROD_W-1:0]  fuel_prod_q;
	logic [FILL_W-1:0]       fill_q;
	logic signed [AVG_W-1:0] avg_out_q;
	logic [FILL_W-1:0]       fill_out_q;
	logic [FUEL_W-1:0]       fuel_out_q;
	logic                    out_valid_q;

	logic [SUM_W-1:0]        mag;
	logic [AVG_W:0]          avg_mag;
	div_req_t                div_req;
	logic                    div_done;
	logic [QUO_W-1:0]        div_quot;
	logic                    seg_hit;
	logic [1:0]              seg_k;
	logic                    above_empty;
	logic [TANK_W-1:0]       tank_sat;
	logic                    emit;

	assign mag      = q_head[SUM_W-1] ? SUM_W'(-q_head) : SUM_W'(q_head);
	assign avg_mag  = avg_prod_q[AVG_SHIFT +: AVG_W + 1];
	assign q_pop    = (state_q == S_IDLE) && !q_stat.empty;
	assign emit     = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	assign tank_sat = (cfg.tank > TANK_MAX) ? TANK_MAX : cfg.tank;

	// first segment holding the average, both ends inclusive
	always_comb begin
		logic [NUM_SEGS-1:0] hit;
		for (int k = 0; k < NUM_SEGS; k++) begin
			hit[k] = (avg_q <= $signed({2'b00, cfg.code[k]})) &&
			         (avg_q >= $signed({2'b00, cfg.code[k+1]}));
		end
		seg_hit = |hit;
		seg_k   = 2'd0;
		for (int k = NUM_SEGS - 1; k >= 0; k--) begin
			if (hit[k]) begin
				seg_k = 2'(k);
			end
		end
		above_empty = avg_q > $signed({2'b00, cfg.code[0]});
	end

	fgai_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		div_req = '0;
		case (state_q)
			S_FILL_GO: begin
				div_req.start     = 1'b1;
				div_req.rem_init  = prod1_q[DVD_W-1:FILL_QBITS];
				div_req.bits_init = {prod1_q[FILL_QBITS-1:0], (DVD_W - FILL_QBITS)'(0)};
				div_req.divisor   = span_q;
				div_req.steps     = FILL_STEPS;
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				neg_q <= q_head[SUM_W-1];
				mag_q <= mag;
			end
			S_AVG_MUL: begin
				avg_prod_q <= AVG_PROD_W'(mag_q) * AVG_PROD_W'(AVG_RECIP);
			end
			S_AVG_SIGN: begin
				avg_q <= neg_q ? $signed(-avg_mag) : $signed(avg_mag);
			end
			S_SEG: begin
				base_q <= FILL_W'(seg_k) * FILL_W'(SEG_CENTI);
				span_q <= CODE_W'(cfg.code[seg_k] - cfg.code[seg_k + 3'd1]);
				dist_q <= CODE_W'($signed({2'b00, cfg.code[seg_k]}) - avg_q);
				if (!seg_hit) begin
					fill_q <= above_empty ? FILL_EMPTY : FILL_FULL;
				end else begin
					// zero-width segment keeps its start level
					fill_q <= FILL_W'(seg_k) * FILL_W'(SEG_CENTI);
				end
			end
			S_MUL1: begin
				prod1_q <= DVD_W'(dist_q) * DVD_W'(SEG_CENTI);
			end
			S_FILL_WAIT: begin
				if (div_done) begin
					fill_q <= base_q + FILL_W'(div_quot[FILL_QBITS-1:0]);
				end
			end
			S_MUL2: begin
				prod2_q <= 25'(fill_q) * 25'(tank_sat);
			end
			S_FUEL_MUL: begin
				fuel_prod_q <= FUEL_PROD_W'(prod2_q) * FUEL_PROD_W'(FUEL_RECIP);
			end
			default: begin
			end
		endcase
		if (emit) begin
			avg_out_q  <= avg_q[AVG_W-1:0];
			fill_out_q <= fill_q;
			fuel_out_q <= fuel_prod_q[FUEL_SHIFT +: FUEL_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_stat.empty) begin
						state_q <= S_AVG_MUL;
					end
				end
				S_AVG_MUL: begin
					state_q <= S_AVG_SIGN;
				end
				S_AVG_SIGN: begin
					state_q <= S_SEG;
				end
				S_SEG: begin
					if (seg_hit &&
					    (cfg.code[seg_k] != cfg.code[seg_k + 3'd1])) begin
						state_q <= S_MUL1;
					end else begin
						state_q <= S_MUL2;
					end
				end
				S_MUL1: begin
					state_q <= S_FILL_GO;
				end
				S_FILL_GO: begin
					state_q <= S_FILL_WAIT;
				end
				S_FILL_WAIT: begin
					if (div_done) begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					state_q <= S_FUEL_MUL;
				end
				S_FUEL_MUL: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign average_code       = avg_out_q;
	assign fill_centi_percent = fill_out_q;
	assign fuel_centi_liter   = fuel_out_q;

endmodule
`default_nettype wire
